// ----- rtl/core/ptwa_pkg.sv -----
// Shared types, codes and index helpers for the page table walker.
package ptwa_pkg;

    localparam int VA_W      = 48;
    localparam int IDX_W     = 9;
    localparam int ENTRY_W   = 64;
    localparam int ADDR_OUT_W = 16;
    localparam int USED_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 4;
    localparam int OUT_DATA_W = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE = 8'd1;

    localparam logic [11:0] TABLE_FLAGS = 12'h007;

    typedef enum logic [1:0] {
        ST_FOUND       = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_NO_FRAMES   = 2'd2,
        ST_FAULT       = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_CLR   = 7'b0001000,
        S_LINK  = 7'b0010000,
        S_ISSUE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Table index of one walk level: level 0 is the top directory, level 3 the leaf table.
    function automatic logic [IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0: idx = va[47:39];
            2'd1: idx = va[38:30];
            2'd2: idx = va[29:21];
            2'd3: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ----- rtl/core/page_table_walk_with_allocate.sv -----
// Four-level page table walker with on-demand table allocation over one table memory.
//
// Channels: the slave stream takes a walk request (tdata: virtual address,
// tuser: create flag). The master stream returns one result per request
// (status, leaf entry byte address, leaf entry value, frames handed out).
// The config channel writes root_frame (index 0) and alloc_base (index 1);
// it is always ready; the user must write it only while no walk is in flight,
// which the block itself does not enforce. Throughput: one walk at a time.
// A walk through existing tables does one table read per level, since all
// four levels share the single read port of the table memory. Each
// allocated table adds a pass that clears its 512 entries, a link write
// and a re-read. A failed walk ends at the level that fails.
// Reset: a clearing pass writes zero to all NUM_FRAMES*512 entries, one
// per cycle, before the first request is accepted; config writes are
// taken during the pass.
// Stall: a finished result waits in the output register; the next request
// is accepted meanwhile and, when done, holds in the walker until the
// output register is free.
module page_table_walk_with_allocate #(
    parameter int NUM_FRAMES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ptwa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptwa_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [ptwa_pkg::VA_W-1:0] i_s_axis_tdata,  // [47:0] virt_address
    input  logic [0:0]  i_s_axis_tuser,                // [0] create
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [17:2] entry_address, [81:18] entry_value, [86:82] frames_used
    output logic [ptwa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int FW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int AW     = FW + ptwa_pkg::IDX_W;
    localparam int STORE  = NUM_FRAMES * 512;
    localparam int CW     = $clog2(NUM_FRAMES + 1);
    localparam int SW     = ((CW > 4) ? CW : 4) + 1;

    // table memory
    logic [ptwa_pkg::ENTRY_W-1:0] mem [STORE];
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [ptwa_pkg::ENTRY_W-1:0] wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [ptwa_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    ptwa_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_alloc_count, n_alloc_count;
    logic [3:0]       r_root_frame, n_root_frame;
    logic [3:0]       r_alloc_base, n_alloc_base;
    logic [ptwa_pkg::VA_W-1:0] r_va, n_va;
    logic             r_create, n_create;
    logic [FW-1:0]    r_frame, n_frame;
    logic [FW-1:0]    r_nf, n_nf;
    logic [1:0]       r_level, n_level;

    ptwa_pkg::t_status r_res_status, n_res_status;
    logic [ptwa_pkg::ADDR_OUT_W-1:0] r_res_addr, n_res_addr;
    logic [ptwa_pkg::ENTRY_W-1:0]    r_res_value, n_res_value;

    logic             r_out_valid, n_out_valid;
    logic [ptwa_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic             s_fire;
    logic             out_free;
    logic             root_ok;
    logic [SW-1:0]    nf_sum;
    logic             nf_ok;
    logic             entry_fault;
    logic [FW-1:0]    entry_frame;
    logic [ptwa_pkg::IDX_W-1:0] cur_idx;
    logic [ptwa_pkg::IDX_W-1:0] nxt_idx;

    // walk end in this cycle
    logic             fin;
    ptwa_pkg::t_status fin_status;
    logic [ptwa_pkg::ADDR_OUT_W-1:0] fin_addr;
    logic [ptwa_pkg::ENTRY_W-1:0]    fin_value;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ptwa_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign s_fire      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign root_ok     = 13'(r_root_frame) < 13'(NUM_FRAMES);
    assign nf_sum      = SW'(r_alloc_base) + SW'(r_alloc_count);
    assign nf_ok       = nf_sum < SW'(NUM_FRAMES);
    assign entry_fault = r_rdata[63:12] >= 52'(NUM_FRAMES);
    assign entry_frame = r_rdata[12 +: FW];
    assign cur_idx     = ptwa_pkg::lvl_index(r_va, r_level);
    assign nxt_idx     = ptwa_pkg::lvl_index(r_va, r_level + 2'd1);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_alloc_count = r_alloc_count;
        n_root_frame  = r_root_frame;
        n_alloc_base  = r_alloc_base;
        n_va          = r_va;
        n_create      = r_create;
        n_frame       = r_frame;
        n_nf          = r_nf;
        n_level       = r_level;
        n_res_status  = r_res_status;
        n_res_addr    = r_res_addr;
        n_res_value   = r_res_value;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        wr_en   = 1'b0;
        wr_addr = r_cnt;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = {r_frame, cur_idx};

        fin        = 1'b0;
        fin_status = ptwa_pkg::ST_FOUND;
        fin_addr   = '0;
        fin_value  = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            if (i_cfg_index == ptwa_pkg::CFG_ROOT_FRAME) begin
                n_root_frame = i_cfg_data;
            end else if (i_cfg_index == ptwa_pkg::CFG_ALLOC_BASE) begin
                n_alloc_base = i_cfg_data;
            end
        end

        unique case (r_state)
            ptwa_pkg::S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == AW'(STORE - 1)) begin
                    n_state = ptwa_pkg::S_IDLE;
                end
            end
            ptwa_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_va     = i_s_axis_tdata;
                    n_create = i_s_axis_tuser[0];
                    n_level  = 2'd0;
                    if (root_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = {FW'(r_root_frame), i_s_axis_tdata[47:39]};
                        n_frame = FW'(r_root_frame);
                        n_state = ptwa_pkg::S_EVAL;
                    end else begin
                        n_res_status = ptwa_pkg::ST_FAULT;
                        n_res_addr   = '0;
                        n_res_value  = '0;
                        n_state      = ptwa_pkg::S_DONE;
                    end
                end
            end
            ptwa_pkg::S_EVAL: begin
                if (r_level == 2'd3) begin
                    fin        = 1'b1;
                    fin_status = ptwa_pkg::ST_FOUND;
                    fin_addr   = {4'(r_frame), cur_idx, 3'b000};
                    fin_value  = r_rdata;
                end else if (r_rdata[0]) begin
                    if (entry_fault) begin
                        fin        = 1'b1;
                        fin_status = ptwa_pkg::ST_FAULT;
                    end else begin
                        // follow the pointer: read the next level right away
                        rd_en   = 1'b1;
                        rd_addr = {entry_frame, nxt_idx};
                        n_frame = entry_frame;
                        n_level = r_level + 2'd1;
                    end
                end else if (!r_create) begin
                    fin        = 1'b1;
                    fin_status = ptwa_pkg::ST_NOT_PRESENT;
                end else if (!nf_ok) begin
                    fin        = 1'b1;
                    fin_status = ptwa_pkg::ST_NO_FRAMES;
                end else begin
                    n_nf          = nf_sum[FW-1:0];
                    n_cnt         = '0;
                    n_alloc_count = r_alloc_count + CW'(1);
                    n_state       = ptwa_pkg::S_CLR;
                end
            end
            ptwa_pkg::S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = {r_nf, r_cnt[ptwa_pkg::IDX_W-1:0]};
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt[ptwa_pkg::IDX_W-1:0] == '1) begin
                    n_state = ptwa_pkg::S_LINK;
                end
            end
            ptwa_pkg::S_LINK: begin
                // point the missing entry at the fresh table
                wr_en   = 1'b1;
                wr_addr = {r_frame, cur_idx};
                wr_data = {{(52 - FW){1'b0}}, r_nf, ptwa_pkg::TABLE_FLAGS};
                n_frame = r_nf;
                n_level = r_level + 2'd1;
                n_state = ptwa_pkg::S_ISSUE;
            end
            ptwa_pkg::S_ISSUE: begin
                // separate cycle: the fresh table may share the linked entry's frame
                rd_en   = 1'b1;
                rd_addr = {r_frame, cur_idx};
                n_state = ptwa_pkg::S_EVAL;
            end
            ptwa_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, 5'(r_alloc_count), r_res_value, r_res_addr,
                                   r_res_status};
                    n_state     = ptwa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptwa_pkg::S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_data  = {1'b0, 5'(n_alloc_count), fin_value, fin_addr, fin_status};
                n_state     = ptwa_pkg::S_IDLE;
            end else begin
                n_res_status = fin_status;
                n_res_addr   = fin_addr;
                n_res_value  = fin_value;
                n_state      = ptwa_pkg::S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ptwa_pkg::S_INIT;
            r_cnt         <= '0;
            r_alloc_count <= '0;
            r_root_frame  <= 4'd0;
            r_alloc_base  <= 4'd1;
            r_out_valid   <= 1'b0;
            r_level       <= 2'd0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_alloc_count <= n_alloc_count;
            r_root_frame  <= n_root_frame;
            r_alloc_base  <= n_alloc_base;
            r_out_valid   <= n_out_valid;
            r_level       <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va         <= n_va;
        r_create     <= n_create;
        r_frame      <= n_frame;
        r_nf         <= n_nf;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_value  <= n_res_value;
        r_out_data   <= n_out_data;
    end

`ifndef SYNTH
    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && root_ok |=> r_state == ptwa_pkg::S_EVAL && r_level == 2'd0)
        else $error("accepted walk did not start at the top level");

    a_alloc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_alloc_count) <= NUM_FRAMES)
        else $error("allocator handed out more frames than the store holds");

    a_link_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ptwa_pkg::S_LINK |-> $past(r_state) == ptwa_pkg::S_CLR)
        else $error("table linked without a full clear");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ($past(r_state) == ptwa_pkg::S_EVAL || $past(r_state) == ptwa_pkg::S_DONE))
        else $error("result loaded outside a walk end");
`endif

endmodule
